>>> rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int OFF_W      = 5;
    localparam int ADDR_W     = 7;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOCHANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic access;
        logic scan;
        logic update;
    } bfa_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       scan_end;
    } bfa_stat_t;

endpackage

>>> rtl/bfa_datapath.sv
`timescale 1ns / 1ps

module bfa_datapath
    import bfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfa_ctrl_t            ctrl,
    output bfa_stat_t            stat,
    input  logic [1:0]           command,
    input  logic [FRAME_W-1:0]   frame_index,
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_data,
    output logic                 result_valid,
    output logic [FRAME_W-1:0]   allocated_frame,
    output logic [1:0]           status,
    output logic [COUNT_W-1:0]   free_count
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    logic [1:0]           cmd_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [ADDR_W-1:0]    word_reg;
    logic [ADDR_W-1:0]    word_next;
    logic [COUNT_W-1:0]   used_count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [COUNT_W-1:0]   frames_in_use_reg;
    logic                 result_valid_reg;
    logic [FRAME_W-1:0]   allocated_frame_reg;
    logic [1:0]           status_reg;
    logic [COUNT_W-1:0]   free_count_reg;

    logic [COUNT_W-1:0]   limit;
    logic [ADDR_W:0]      lim_hi;
    logic [OFF_W-1:0]     lim_lo;
    logic [ADDR_W:0]      word_ext;
    logic [ADDR_W:0]      next_base;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [OFF_W-1:0]     first_idx;
    logic                 found;
    logic                 scan_last;
    logic [ADDR_W-1:0]    rd_addr;
    logic [OFF_W-1:0]     bit_off;
    logic                 bit_set;
    logic                 in_range;

    logic                 mem_we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 res_fire;
    logic [1:0]           res_status;
    logic [FRAME_W-1:0]   res_frame;
    logic                 clear_all;
    logic [COUNT_W-1:0]   free_calc;

    assign limit = (frames_in_use_reg > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                              : frames_in_use_reg;
    assign lim_hi    = limit[COUNT_W-1:OFF_W];
    assign lim_lo    = limit[OFF_W-1:0];
    assign word_ext  = {1'b0, word_reg};
    assign next_base = word_ext + (ADDR_W+1)'(1);
    assign scan_last = {next_base, {OFF_W{1'b0}}} >= limit;
    assign cur_word  = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        if (word_ext < lim_hi)
        begin
            mask = '1;
        end
        else if (word_ext == lim_hi)
        begin
            mask = (WORD_BITS'(1) << lim_lo) - WORD_BITS'(1);
        end
        else
        begin
            mask = '0;
        end
    end

    assign free_bits = ~cur_word & mask;
    assign found     = |free_bits;

    always_comb
    begin
        first_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                first_idx = OFF_W'(i);
            end
        end
    end

    assign bit_off  = frame_reg[OFF_W-1:0];
    assign bit_set  = cur_word[bit_off];
    assign in_range = {1'b0, frame_reg} < limit;

    always_comb
    begin
        if (ctrl.access)
        begin
            rd_addr = (cmd_reg == CMD_ALLOC) ? '0 : frame_reg[FRAME_W-1:OFF_W];
        end
        else
        begin
            rd_addr = word_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        mem_we     = 1'b0;
        waddr      = word_reg;
        wdata      = cur_word;
        count_next = used_count_reg;
        res_fire   = 1'b0;
        res_status = ST_DONE;
        res_frame  = '0;
        clear_all  = 1'b0;
        word_next  = word_reg;
        if (ctrl.access)
        begin
            word_next = '0;
            if (cmd_reg == CMD_CLEAR)
            begin
                clear_all  = 1'b1;
                count_next = '0;
                res_fire   = 1'b1;
            end
        end
        else if (ctrl.scan)
        begin
            word_next = word_reg + ADDR_W'(1);
            if (found)
            begin
                mem_we     = 1'b1;
                wdata      = cur_word | (WORD_BITS'(1) << first_idx);
                count_next = used_count_reg + COUNT_W'(1);
                res_frame  = {word_reg, first_idx};
                res_fire   = 1'b1;
            end
            else if (scan_last)
            begin
                res_status = ST_OOM;
                res_fire   = 1'b1;
            end
        end
        else if (ctrl.update)
        begin
            waddr    = frame_reg[FRAME_W-1:OFF_W];
            res_fire = 1'b1;
            if (!in_range)
            begin
                res_status = ST_RANGE;
            end
            else if (cmd_reg == CMD_FREE)
            begin
                if (!bit_set)
                begin
                    res_status = ST_NOCHANGE;
                end
                else
                begin
                    mem_we = 1'b1;
                    wdata  = cur_word & ~(WORD_BITS'(1) << bit_off);
                    if (used_count_reg != '0)
                    begin
                        count_next = used_count_reg - COUNT_W'(1);
                    end
                end
            end
            else
            begin
                if (bit_set)
                begin
                    res_status = ST_NOCHANGE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wdata      = cur_word | (WORD_BITS'(1) << bit_off);
                    count_next = used_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    assign free_calc = (count_next < limit) ? (limit - count_next) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                word_valid_reg <= '0;
            end
            else if (mem_we)
            begin
                word_valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg    <= '0;
            frames_in_use_reg <= COUNT_W'(MAX_FRAMES);
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            used_count_reg   <= count_next;
            result_valid_reg <= res_fire;
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (ctrl.load)
        begin
            cmd_reg   <= command;
            frame_reg <= frame_index;
        end
        if (res_fire)
        begin
            allocated_frame_reg <= res_frame;
            status_reg          <= res_status;
            free_count_reg      <= free_calc;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.scan_end = found || scan_last;

    assign result_valid    = result_valid_reg;
    assign allocated_frame = allocated_frame_reg;
    assign status          = status_reg;
    assign free_count      = free_count_reg;

endmodule

>>> rtl/bfa_controller.sv
`timescale 1ns / 1ps

module bfa_controller
    import bfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output bfa_ctrl_t ctrl,
    input  bfa_stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                ctrl.access = 1'b1;
                if (stat.cmd == CMD_CLEAR)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cmd == CMD_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/bitmap_frame_allocator_core.sv
`timescale 1ns / 1ps

// First-fit page frame allocator over 4096 frames, kept as 128 words of 32 used bits.
// A command is taken when start is high and busy is low, and its single result appears
// on the result ports for exactly one cycle with result_valid high; the receiver cannot
// stall it, so it must take every result as it comes. Clear completes in the access state;
// free and mark-used read the word in the access state and write it in the update state;
// allocate reads the bitmap words in turn in the scan state until it finds a free frame or
// passes the limit, one word per cycle through the single read port of the bitmap memory.
// The frame limit may be written only while the block is idle and no result is pending.

module bitmap_frame_allocator_core
    import bfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [FRAME_W-1:0] frame_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               result_valid,
    output logic [FRAME_W-1:0] allocated_frame,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] free_count
);

    bfa_ctrl_t ctrl;
    bfa_stat_t stat;

    assign cfg_ready = 1'b1;

    bfa_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    bfa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .command         (command),
        .frame_index     (frame_index),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .allocated_frame (allocated_frame),
        .status          (status),
        .free_count      (free_count)
    );

`ifndef SYNTHESIS
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while a command is still in progress");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_frame_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_DONE) |-> (allocated_frame == '0))
        else $error("nonzero frame reported with a failing status");

    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (free_count <= COUNT_W'(MAX_FRAMES)))
        else $error("free count exceeds the number of frames");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bfa_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [1:0]         st;
        logic [COUNT_W-1:0] free;
    } frame_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [FRAME_W-1:0] frame_index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    logic               result_valid;
    logic [FRAME_W-1:0] allocated_frame;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_count;

    logic [MAX_FRAMES-1:0] frame_used;
    int unsigned           used_total;
    logic [COUNT_W-1:0]    frames_in_use;
    frame_result_t         pending_results[$];

    int idle_pct;
    int err_cnt;
    int item_cnt;
    int cfg_cnt;
    int high_frame;
    int status_hits[4];

    bitmap_frame_allocator_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .frame_index     (frame_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .allocated_frame (allocated_frame),
        .status          (status),
        .free_count      (free_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned active_limit();
        return (frames_in_use > COUNT_W'(MAX_FRAMES)) ? MAX_FRAMES : 32'(frames_in_use);
    endfunction

    function automatic frame_result_t predict_frame_op(input logic [1:0] c,
                                                       input logic [FRAME_W-1:0] f);
        frame_result_t r;
        int unsigned   lim;
        int unsigned   i;
        bit            found;
        lim = active_limit();
        r.frame = '0;
        r.st = ST_DONE;
        found = 1'b0;
        case (c)
            CMD_ALLOC:
            begin
                i = 0;
                while (!found && i < lim)
                begin
                    if (!frame_used[i])
                    begin
                        frame_used[i] = 1'b1;
                        used_total++;
                        r.frame = i[FRAME_W-1:0];
                        found = 1'b1;
                        if (i > high_frame)
                            high_frame = i;
                    end
                    i++;
                end
                if (!found)
                    r.st = ST_OOM;
            end
            CMD_FREE:
            begin
                if (f >= lim)
                    r.st = ST_RANGE;
                else if (!frame_used[f])
                    r.st = ST_NOCHANGE;
                else
                begin
                    frame_used[f] = 1'b0;
                    if (used_total > 0)
                        used_total--;
                end
            end
            CMD_MARK:
            begin
                if (f >= lim)
                    r.st = ST_RANGE;
                else if (frame_used[f])
                    r.st = ST_NOCHANGE;
                else
                begin
                    frame_used[f] = 1'b1;
                    used_total++;
                end
            end
            default:
            begin
                frame_used = '0;
                used_total = 0;
            end
        endcase
        r.free = (used_total < lim) ? COUNT_W'(lim - used_total) : '0;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got frame %0d status %0d free %0d",
                         $time, allocated_frame, status, free_count);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("allocated_frame", COUNT_W'(want.frame), COUNT_W'(allocated_frame));
                check_field("status", COUNT_W'(want.st), COUNT_W'(status));
                check_field("free_count", want.free, free_count);
                status_hits[want.st]++;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] c, input logic [FRAME_W-1:0] f);
        if (!start)
            start <= 1'b1;
        command <= c;
        frame_index <= f;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_frame_op(c, f));
        item_cnt++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        if (start)
            start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_frame_limit(input logic [COUNT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frames_in_use = v;
        cfg_cnt++;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int n, input int w_alloc, input int w_free, input int w_mark,
                           input int span_pct);
        int                 pick;
        int unsigned        lim;
        logic [1:0]         c;
        logic [FRAME_W-1:0] f;
        repeat (n)
        begin
            pick = $urandom_range(99);
            lim = active_limit();
            if (pick < w_alloc)
                c = CMD_ALLOC;
            else if (pick < w_alloc + w_free)
                c = CMD_FREE;
            else if (pick < w_alloc + w_free + w_mark)
                c = CMD_MARK;
            else
                c = CMD_CLEAR;
            if (lim != 0 && $urandom_range(99) < span_pct)
                f = FRAME_W'($urandom_range(lim - 1));
            else
                f = FRAME_W'($urandom_range(MAX_FRAMES - 1));
            send_cmd(c, f);
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_cmd(CMD_ALLOC, 12'hFFF);
        send_cmd(CMD_MARK, 12'd4095);
        send_cmd(CMD_MARK, 12'd4095);
        send_cmd(CMD_FREE, 12'd4095);
        send_cmd(CMD_FREE, 12'd4095);
        send_cmd(CMD_FREE, 12'd0);
        write_frame_limit(13'h1FFF);
        send_cmd(CMD_MARK, 12'd4095);
        send_cmd(CMD_CLEAR, 12'd0);
        write_frame_limit(13'd0);
        send_cmd(CMD_ALLOC, 12'd0);
        send_cmd(CMD_FREE, 12'd0);
        send_cmd(CMD_MARK, 12'd0);
        send_cmd(CMD_CLEAR, 12'hFFF);
        write_frame_limit(13'd1);
        send_cmd(CMD_ALLOC, 12'd0);
        send_cmd(CMD_ALLOC, 12'd0);
        send_cmd(CMD_FREE, 12'd1);
        send_cmd(CMD_MARK, 12'd0);
        write_frame_limit(13'd4096);
        send_cmd(CMD_MARK, 12'd100);
        send_cmd(CMD_MARK, 12'd2000);
        // The limit drops below the used count, so the free count must saturate at zero.
        write_frame_limit(13'd2);
        send_cmd(CMD_ALLOC, 12'd0);
        send_cmd(CMD_ALLOC, 12'd0);
        send_cmd(CMD_FREE, 12'd100);
        send_cmd(CMD_CLEAR, 12'd0);
        // Clear must also have wiped the frames above the old limit.
        write_frame_limit(13'd4096);
        send_cmd(CMD_MARK, 12'd2000);
        send_cmd(CMD_ALLOC, 12'd0);
    endtask

    task automatic test_fill_small();
        int sizes[4];
        sizes[0] = 32;
        sizes[1] = 33;
        sizes[2] = $urandom_range(96, 1);
        sizes[3] = $urandom_range(300, 97);
        idle_pct = 58;
        foreach (sizes[k])
        begin
            write_frame_limit(COUNT_W'(sizes[k]));
            send_cmd(CMD_CLEAR, FRAME_W'($urandom_range(MAX_FRAMES - 1)));
            run_mix(110, 60, 25, 10, 90);
        end
    endtask

    task automatic test_full_range();
        idle_pct = 31;
        write_frame_limit(13'd4096);
        run_mix(180, 40, 25, 30, 20);
        write_frame_limit(13'h1FFF);
        run_mix(180, 40, 25, 30, 20);
    endtask

    task automatic test_shrink_limit();
        idle_pct = 0;
        write_frame_limit(13'd4096);
        send_cmd(CMD_CLEAR, 12'd0);
        run_mix(80, 70, 10, 20, 100);
        write_frame_limit((used_total > 1) ? COUNT_W'($urandom_range(used_total - 1, 1))
                                           : COUNT_W'(1));
        run_mix(60, 40, 30, 25, 90);
        write_frame_limit(COUNT_W'($urandom_range(8191, 4097)));
        run_mix(60, 40, 30, 25, 90);
    endtask

    task automatic test_noise();
        for (int round = 0; round < 5; round++)
        begin
            idle_pct = (round < 3) ? 58 : 31;
            write_frame_limit(COUNT_W'($urandom_range(8191)));
            run_mix(90, 30, 30, 30, 50);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_ALLOC;
        frame_index = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        frame_used = '0;
        used_total = 0;
        frames_in_use = COUNT_W'(MAX_FRAMES);
        idle_pct = 0;
        err_cnt = 0;
        item_cnt = 0;
        cfg_cnt = 0;
        high_frame = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_small();
        test_full_range();
        test_shrink_limit();
        test_noise();

        drain_results();
        repeat (140)
            @(posedge clk);
        $display("Ran %0d commands across %0d frame-limit settings, highest frame granted %0d.",
                 item_cnt, cfg_cnt, high_frame);
        $display("Outcomes: %0d done, %0d out of memory, %0d out of range, %0d no change.",
                 status_hits[ST_DONE], status_hits[ST_OOM], status_hits[ST_RANGE],
                 status_hits[ST_NOCHANGE]);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
